[hdl/irbpd_pkg.sv]
// -----------------------------------------------------------------------------
// IR beacon pulse decoder package
// Register indexes, beacon codes, slot patterns and decoder constants.
// -----------------------------------------------------------------------------
package irbpd_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_SHORT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_LONG  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FALL_SHORT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FALL_LONG  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLASS_BITS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SECTOR = 3'd5;

  // Register widths and reset values
  localparam int unsigned REF_W   = 16;
  localparam int unsigned CLASS_W = 4;
  localparam int unsigned MS_W    = 24;

  localparam logic [REF_W-1:0]   RISE_SHORT_RST = 16'd500;
  localparam logic [REF_W-1:0]   RISE_LONG_RST  = 16'd1000;
  localparam logic [REF_W-1:0]   FALL_SHORT_RST = 16'd500;
  localparam logic [REF_W-1:0]   FALL_LONG_RST  = 16'd1000;
  localparam logic [CLASS_W-1:0] CLASS_BITS_RST = 4'd10;
  localparam logic [MS_W-1:0]    MIN_SECTOR_RST = 24'd1000;

  // Beacon codes
  localparam int unsigned BEACON_W = 2;
  localparam logic [BEACON_W-1:0] BEACON_FINISH  = 2'd0;
  localparam logic [BEACON_W-1:0] BEACON_SECTOR1 = 2'd1;
  localparam logic [BEACON_W-1:0] BEACON_SECTOR2 = 2'd2;
  localparam logic [BEACON_W-1:0] BEACON_SECTOR3 = 2'd3;

  // Slot register and beacon patterns
  localparam int unsigned SLOTS  = 8;
  localparam int unsigned SLOT_W = 3;
  localparam logic [SLOTS-1:0] PAT_FINISH  = 8'b0000_0000;
  localparam logic [SLOTS-1:0] PAT_SECTOR1 = 8'b1010_1010;
  localparam logic [SLOTS-1:0] PAT_SECTOR2 = 8'b0101_0101;
  localparam logic [SLOTS-1:0] PAT_SECTOR3 = 8'b1111_1111;
  localparam logic [SLOTS-1:0] SLOTS_ALL   = 8'b1111_1111;

  // Pulse width tolerance, strictly below this many microseconds
  localparam int unsigned TOLERANCE_US = 100;

  // Elapsed time output
  localparam int unsigned       ELAPSED_W   = 24;
  localparam logic [31:0]       ELAPSED_MAX = 32'h00FF_FFFF;

endpackage

[hdl/ir_beacon_pulse_decoder.sv]
// An accepted word is held in the input register; a beacon it completes then loads the result register.
// Throughput: one sample word per cycle; the input stage and result register
// decouple the channels, and only a stalled full result register holds input.
// Reset (rst_ni low, asynchronous): registers go to their documented defaults,
// the pin history reads high, all counters and slots clear, no result pending.
// -----------------------------------------------------------------------------
// IR beacon pulse decoder
// Measures pulses between pin edges, classifies them into an 8-slot rolling
// register and reports finish or sector beacons with their elapsed time.
// -----------------------------------------------------------------------------
module ir_beacon_pulse_decoder #(
  parameter int unsigned PULSE_COUNT_BITS = 16,
  parameter int unsigned TIME_COUNT_BITS  = 24
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration write port
  input  logic                                  cfg_we_i,
  input  logic [irbpd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [irbpd_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // sample channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  pin_level_i,
  input  logic                                  ms_tick_i,
  // beacon channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [irbpd_pkg::BEACON_W-1:0]        beacon_id_o,
  output logic [irbpd_pkg::ELAPSED_W-1:0]       elapsed_ms_o
);

  import irbpd_pkg::*;

  localparam int unsigned PW = PULSE_COUNT_BITS;
  localparam int unsigned TW = TIME_COUNT_BITS;
  // width used to compare pulse widths against 16-bit references
  localparam int unsigned DW = (PW > REF_W) ? PW : REF_W;

  localparam logic [PW-1:0] PULSE_MAX = {PW{1'b1}};
  localparam logic [TW-1:0] TIME_MAX  = {TW{1'b1}};

  // configuration registers
  logic [REF_W-1:0]   rise_short_q, rise_long_q, fall_short_q, fall_long_q;
  logic [CLASS_W-1:0] class_bits_q;
  logic [MS_W-1:0]    min_sector_q;

  // input stage
  logic in_valid_q;
  logic pin_q, tick_q;
  logic in_accept, advance, process;

  // decoder state
  logic              level_q, level_d;
  logic [PW-1:0]     pulse_q, pulse_d, pulse_inc;
  logic [SLOTS-1:0]  bits_q, bits_d, bits_cls;
  logic [SLOTS-1:0]  valids_q, valids_d, valids_cls;
  logic [SLOT_W-1:0] pos_q, pos_d;
  logic [TW-1:0]     sector_q, sector_d, sector_inc;
  logic [TW-1:0]     lap_q, lap_d, lap_inc;

  // result register
  logic                 out_valid_q;
  logic [BEACON_W-1:0]  beacon_q;
  logic [ELAPSED_W-1:0] elapsed_q;

  // step intermediates
  logic              unlocked, edge_seen, rising;
  logic [DW-1:0]     width_ext, s_ref_ext, l_ref_ext, s_diff, l_diff;
  logic              s_near, l_near, cls_hit, cls_bit;
  logic [1:0]        cls_idx;
  logic [SLOTS-1:0]  slot_mask;
  logic              beacon_hit;
  logic [BEACON_W-1:0] beacon_d;
  logic [TW-1:0]     elapsed_raw;
  logic [31:0]       elapsed_ext;
  logic [ELAPSED_W-1:0] elapsed_d;

  // handshake: the input stage moves on when the result register can take a word
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign process    = in_valid_q && advance;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_short_q <= RISE_SHORT_RST;
      rise_long_q  <= RISE_LONG_RST;
      fall_short_q <= FALL_SHORT_RST;
      fall_long_q  <= FALL_LONG_RST;
      class_bits_q <= CLASS_BITS_RST;
      min_sector_q <= MIN_SECTOR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_RISE_SHORT: rise_short_q <= cfg_data_i[REF_W-1:0];
        CFG_RISE_LONG:  rise_long_q  <= cfg_data_i[REF_W-1:0];
        CFG_FALL_SHORT: fall_short_q <= cfg_data_i[REF_W-1:0];
        CFG_FALL_LONG:  fall_long_q  <= cfg_data_i[REF_W-1:0];
        CFG_CLASS_BITS: class_bits_q <= cfg_data_i[CLASS_W-1:0];
        CFG_MIN_SECTOR: min_sector_q <= cfg_data_i[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pin_q  <= pin_level_i;
      tick_q <= ms_tick_i;
    end
  end

  // saturating counter advances
  assign pulse_inc  = (pulse_q == PULSE_MAX) ? PULSE_MAX : pulse_q + PW'(1);
  assign sector_inc = !tick_q ? sector_q :
                      ((sector_q == TIME_MAX) ? TIME_MAX : sector_q + TW'(1));
  assign lap_inc    = !tick_q ? lap_q :
                      ((lap_q == TIME_MAX) ? TIME_MAX : lap_q + TW'(1));

  // lockout and edge detection
  assign unlocked  = 32'(sector_inc) >= 32'(min_sector_q);
  assign edge_seen = unlocked && (pin_q != level_q);
  assign rising    = pin_q;

  // classify the pulse against the references of its edge type
  assign width_ext = DW'(pulse_inc);
  assign s_ref_ext = DW'(rising ? rise_short_q : fall_short_q);
  assign l_ref_ext = DW'(rising ? rise_long_q : fall_long_q);
  assign s_diff    = (width_ext >= s_ref_ext) ? width_ext - s_ref_ext : s_ref_ext - width_ext;
  assign l_diff    = (width_ext >= l_ref_ext) ? width_ext - l_ref_ext : l_ref_ext - width_ext;
  assign s_near    = s_diff < DW'(TOLERANCE_US);
  assign l_near    = l_diff < DW'(TOLERANCE_US);
  assign cls_hit   = s_near || l_near;
  // short wins when both match
  assign cls_idx   = {!rising, !s_near};
  assign cls_bit   = class_bits_q[cls_idx];
  assign slot_mask = SLOTS'(1) << pos_q;

  assign valids_cls = cls_hit ? (valids_q | slot_mask) : (valids_q & ~slot_mask);
  assign bits_cls   = !cls_hit ? bits_q :
                      (cls_bit ? (bits_q | slot_mask) : (bits_q & ~slot_mask));

  // next state and beacon match
  always_comb begin
    level_d     = level_q;
    pulse_d     = pulse_inc;
    sector_d    = sector_inc;
    lap_d       = lap_inc;
    bits_d      = bits_q;
    valids_d    = valids_q;
    pos_d       = pos_q;
    beacon_hit  = 1'b0;
    beacon_d    = BEACON_FINISH;
    elapsed_raw = sector_inc;

    // take the pulse into its slot
    if (edge_seen) begin
      level_d  = pin_q;
      pulse_d  = '0;
      bits_d   = bits_cls;
      valids_d = valids_cls;
      pos_d    = pos_q + SLOT_W'(1);
    end

    // match a full slot register against the beacon patterns
    if (unlocked && (valids_d == SLOTS_ALL)) begin
      priority if (bits_d == PAT_FINISH) begin
        beacon_hit  = 1'b1;
        beacon_d    = BEACON_FINISH;
        elapsed_raw = lap_inc;
      end else if (bits_d == PAT_SECTOR1) begin
        beacon_hit = 1'b1;
        beacon_d   = BEACON_SECTOR1;
      end else if (bits_d == PAT_SECTOR2) begin
        beacon_hit = 1'b1;
        beacon_d   = BEACON_SECTOR2;
      end else if (bits_d == PAT_SECTOR3) begin
        beacon_hit = 1'b1;
        beacon_d   = BEACON_SECTOR3;
      end else begin
        beacon_hit = 1'b0;
      end
    end

    // after a beacon restart slots and sector timer, and the lap timer on a finish
    if (beacon_hit) begin
      sector_d = '0;
      bits_d   = '0;
      valids_d = '0;
      pos_d    = '0;
      if (beacon_d == BEACON_FINISH) begin
        lap_d = '0;
      end
    end
  end

  // clamp the elapsed time to the output width
  assign elapsed_ext = 32'(elapsed_raw);
  assign elapsed_d   = (elapsed_ext > ELAPSED_MAX) ? ELAPSED_MAX[ELAPSED_W-1:0]
                                                   : elapsed_ext[ELAPSED_W-1:0];

  // state update, one step per processed word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q  <= 1'b1;
      pulse_q  <= '0;
      bits_q   <= '0;
      valids_q <= '0;
      pos_q    <= '0;
      sector_q <= '0;
      lap_q    <= '0;
    end else if (process) begin
      level_q  <= level_d;
      pulse_q  <= pulse_d;
      bits_q   <= bits_d;
      valids_q <= valids_d;
      pos_q    <= pos_d;
      sector_q <= sector_d;
      lap_q    <= lap_d;
    end
  end

  // result register: load on a beacon, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (process && beacon_hit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process && beacon_hit) begin
      beacon_q  <= beacon_d;
      elapsed_q <= elapsed_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign beacon_id_o  = beacon_q;
  assign elapsed_ms_o = elapsed_q;

endmodule

[dv/ir_beacon_pulse_decoder_checker.sv]
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// IR beacon pulse decoder checker
// Tracks configuration writes, models the decoder on every accepted sample
// word and compares every accepted beacon word with the oldest predicted one.
// -----------------------------------------------------------------------------
module ir_beacon_pulse_decoder_checker #(
  parameter int unsigned PULSE_COUNT_BITS = 16,
  parameter int unsigned TIME_COUNT_BITS  = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [irbpd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [irbpd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic                             pin_level_i,
  input  logic                             ms_tick_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic [irbpd_pkg::BEACON_W-1:0]   beacon_id_i,
  input  logic [irbpd_pkg::ELAPSED_W-1:0]  elapsed_ms_i,
  output int                               fail_cnt_o,
  output int                               pending_o
);
  import irbpd_pkg::*;

  // Pulse classes, also the bit index into the class value register
  localparam int CLASS_NONE       = -1;
  localparam int CLASS_RISE_SHORT = 0;
  localparam int CLASS_RISE_LONG  = 1;
  localparam int CLASS_FALL_SHORT = 2;
  localparam int CLASS_FALL_LONG  = 3;

  typedef struct packed {
    logic [BEACON_W-1:0]  id;
    logic [ELAPSED_W-1:0] ms;
  } beacon_t;

  // Shadow configuration
  logic [REF_W-1:0]   rise_short_q;
  logic [REF_W-1:0]   rise_long_q;
  logic [REF_W-1:0]   fall_short_q;
  logic [REF_W-1:0]   fall_long_q;
  logic [CLASS_W-1:0] class_bits_q;
  logic [MS_W-1:0]    min_sector_q;

  // Decoder state
  logic                        pin_hist_q;
  logic [PULSE_COUNT_BITS-1:0] pulse_us_q;
  logic [SLOTS-1:0]            slot_bits_q;
  logic [SLOTS-1:0]            slot_valid_q;
  logic [SLOT_W-1:0]           slot_pos_q;
  logic [TIME_COUNT_BITS-1:0]  sector_ms_q;
  logic [TIME_COUNT_BITS-1:0]  lap_ms_q;

  beacon_t beacon_q[$];
  beacon_t want;
  int      errors;

  // Width within tolerance of a reference, strictly
  function automatic logic near_ref(input logic [PULSE_COUNT_BITS-1:0] width,
                                    input logic [REF_W-1:0] ref_us);
    longint wd;
    longint rd;
    longint d;
    wd = width;
    rd = ref_us;
    d  = wd - rd;
    if (d < 0) d = -d;
    return d < TOLERANCE_US;
  endfunction

  // Advance the model by one sample word, queue a beacon if one completes
  task automatic decode_sample(input logic pin, input logic tick);
    logic                       rising;
    logic [REF_W-1:0]           s_ref;
    logic [REF_W-1:0]           l_ref;
    logic [SLOTS-1:0]           mask;
    logic [TIME_COUNT_BITS-1:0] span;
    logic                       hit;
    int                         cls;
    beacon_t                    b;

    if (pulse_us_q != '1) pulse_us_q = pulse_us_q + 1'b1;
    if (tick) begin
      if (sector_ms_q != '1) sector_ms_q = sector_ms_q + 1'b1;
      if (lap_ms_q != '1) lap_ms_q = lap_ms_q + 1'b1;
    end

    // lockout: pin ignored, pulse keeps counting
    if (sector_ms_q < min_sector_q) return;

    if (pin != pin_hist_q) begin
      rising = pin;
      s_ref  = rising ? rise_short_q : fall_short_q;
      l_ref  = rising ? rise_long_q : fall_long_q;
      cls    = CLASS_NONE;
      // short wins when both references are close
      if (near_ref(pulse_us_q, s_ref)) cls = rising ? CLASS_RISE_SHORT : CLASS_FALL_SHORT;
      else if (near_ref(pulse_us_q, l_ref)) cls = rising ? CLASS_RISE_LONG : CLASS_FALL_LONG;
      pin_hist_q = pin;
      pulse_us_q = '0;
      mask = '0;
      mask[slot_pos_q] = 1'b1;
      if (cls == CLASS_NONE) begin
        // unclassified: drop the valid bit, keep the old bit
        slot_valid_q = slot_valid_q & ~mask;
      end else begin
        slot_valid_q = slot_valid_q | mask;
        if (class_bits_q[cls]) slot_bits_q = slot_bits_q | mask;
        else slot_bits_q = slot_bits_q & ~mask;
      end
      slot_pos_q = slot_pos_q + 1'b1;
    end

    if (slot_valid_q != SLOTS_ALL) return;

    hit  = 1'b1;
    span = sector_ms_q;
    case (slot_bits_q)
      PAT_FINISH: begin
        b.id     = BEACON_FINISH;
        span     = lap_ms_q;
        lap_ms_q = '0;
      end
      PAT_SECTOR1: b.id = BEACON_SECTOR1;
      PAT_SECTOR2: b.id = BEACON_SECTOR2;
      PAT_SECTOR3: b.id = BEACON_SECTOR3;
      default: hit = 1'b0;
    endcase
    if (!hit) return;

    b.ms = (span > ELAPSED_MAX) ? ELAPSED_MAX[ELAPSED_W-1:0] : ELAPSED_W'(span);
    sector_ms_q  = '0;
    slot_bits_q  = '0;
    slot_valid_q = '0;
    slot_pos_q   = '0;
    beacon_q.push_back(b);
  endtask

  // Watch all channels: config, then sample words, then beacon words
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_short_q = RISE_SHORT_RST;
      rise_long_q  = RISE_LONG_RST;
      fall_short_q = FALL_SHORT_RST;
      fall_long_q  = FALL_LONG_RST;
      class_bits_q = CLASS_BITS_RST;
      min_sector_q = MIN_SECTOR_RST;
      pin_hist_q   = 1'b1;
      pulse_us_q   = '0;
      slot_bits_q  = '0;
      slot_valid_q = '0;
      slot_pos_q   = '0;
      sector_ms_q  = '0;
      lap_ms_q     = '0;
      errors       = 0;
      beacon_q.delete();
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_RISE_SHORT: rise_short_q = cfg_data_i[REF_W-1:0];
          CFG_RISE_LONG:  rise_long_q  = cfg_data_i[REF_W-1:0];
          CFG_FALL_SHORT: fall_short_q = cfg_data_i[REF_W-1:0];
          CFG_FALL_LONG:  fall_long_q  = cfg_data_i[REF_W-1:0];
          CFG_CLASS_BITS: class_bits_q = cfg_data_i[CLASS_W-1:0];
          CFG_MIN_SECTOR: min_sector_q = cfg_data_i[MS_W-1:0];
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) decode_sample(pin_level_i, ms_tick_i);

      if (out_valid_i && !out_stall_i) begin
        if (beacon_q.size() == 0) begin
          $display("%0t: beacon word with none predicted: expected none, got id %0d elapsed %0d",
                   $time, beacon_id_i, elapsed_ms_i);
          errors++;
        end else begin
          want = beacon_q.pop_front();
          if (beacon_id_i !== want.id) begin
            $display("%0t: beacon_id mismatch: expected %0d, got %0d",
                     $time, want.id, beacon_id_i);
            errors++;
          end
          if (elapsed_ms_i !== want.ms) begin
            $display("%0t: elapsed_ms mismatch: expected %0d, got %0d",
                     $time, want.ms, elapsed_ms_i);
            errors++;
          end
        end
      end

      fail_cnt_o <= errors;
      pending_o  <= beacon_q.size();
    end
  end

endmodule

[dv/ir_beacon_pulse_decoder_tb.sv]
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// IR beacon pulse decoder testbench
// Drives pulse trains on the sample channel under several register settings
// and idle patterns; the checker predicts and compares every beacon word.
// -----------------------------------------------------------------------------
module ir_beacon_pulse_decoder_tb;
  import irbpd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_500_000;
  localparam int unsigned RANDOM_WORDS = 1550;
  localparam int unsigned PHASE_WORDS  = 130;
  localparam int unsigned LOCK_WORDS   = 40;
  localparam int unsigned MIN_BEACONS  = 36;
  localparam int unsigned MAX_PHASES   = 40;
  localparam int unsigned DRAIN_PULSE  = 10;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  pin_level_i = 1'b1;
  logic                  ms_tick_i   = 1'b0;
  logic                  out_stall_i = 1'b0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic [BEACON_W-1:0]   beacon_id_o;
  logic [ELAPSED_W-1:0]  elapsed_ms_o;

  int   mismatch_cnt;
  int   beacons_pending;
  int   beacons_seen = 0;
  int   cycle_cnt    = 0;
  int   idle_pct     = 0;
  int   stall_pct    = 0;
  logic cur_pin      = 1'b1;

  ir_beacon_pulse_decoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pin_level_i  (pin_level_i),
    .ms_tick_i    (ms_tick_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .beacon_id_o  (beacon_id_o),
    .elapsed_ms_o (elapsed_ms_o)
  );

  ir_beacon_pulse_decoder_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .pin_level_i  (pin_level_i),
    .ms_tick_i    (ms_tick_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .beacon_id_i  (beacon_id_o),
    .elapsed_ms_i (elapsed_ms_o),
    .fail_cnt_o   (mismatch_cnt),
    .pending_o    (beacons_pending)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Random back-pressure on the beacon channel
  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  // Count beacon words for the stop condition
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) beacons_seen <= beacons_seen + 1;
  end

  // Hard stop on a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one sample word after random idle cycles, hold it until taken
  task automatic send_word(input logic pin, input logic tick);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    pin_level_i <= pin;
    ms_tick_i   <= tick;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Flip the pin and hold the new level for a number of samples
  task automatic send_pulse(input int width, input int tick_pct);
    cur_pin = ~cur_pin;
    repeat (width) send_word(cur_pin, ($urandom_range(99) < tick_pct));
  endtask

  // Stop offering words until every predicted beacon has arrived
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (beacons_pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
  endtask

  // Quiesce the decoder, then load a full register set
  task automatic load_regs(input logic [REF_W-1:0] rs, input logic [REF_W-1:0] rl,
                           input logic [REF_W-1:0] fs, input logic [REF_W-1:0] fl,
                           input logic [CLASS_W-1:0] cls, input logic [MS_W-1:0] lock);
    drain_results();
    repeat (4) @(posedge clk_i);
    write_reg(CFG_RISE_SHORT, CFG_DATA_W'(rs));
    write_reg(CFG_RISE_LONG,  CFG_DATA_W'(rl));
    write_reg(CFG_FALL_SHORT, CFG_DATA_W'(fs));
    write_reg(CFG_FALL_LONG,  CFG_DATA_W'(fl));
    write_reg(CFG_CLASS_BITS, CFG_DATA_W'(cls));
    write_reg(CFG_MIN_SECTOR, CFG_DATA_W'(lock));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // References near small widths, on the tolerance boundary, far, or extreme
  function automatic logic [REF_W-1:0] pick_ref();
    case ($urandom_range(9))
      0, 1, 2, 3: return REF_W'($urandom_range(15));
      4, 5, 6:    return REF_W'($urandom_range(115, 95));
      7:          return REF_W'($urandom_range(65535));
      8:          return '1;
      default:    return '0;
    endcase
  endfunction

  // Class values that turn any valid run into a beacon, or random ones
  function automatic logic [CLASS_W-1:0] pick_class();
    if ($urandom_range(9) < 6) begin
      case ($urandom_range(3))
        0:       return 4'b0000;
        1:       return 4'b1111;
        2:       return 4'b0011;
        default: return 4'b1100;
      endcase
    end
    return CLASS_W'($urandom_range(15));
  endfunction

  function automatic logic [MS_W-1:0] pick_lockout();
    int r;
    r = $urandom_range(9);
    if (r < 5) return '0;
    if (r < 9) return MS_W'($urandom_range(4, 1));
    return MS_W'($urandom_range(12, 5));
  endfunction

  function automatic int pick_width();
    int r;
    r = $urandom_range(99);
    if (r < 4) return $urandom_range(220, 13);
    if (r < 30) return $urandom_range(2, 1);
    return $urandom_range(6, 1);
  endfunction

  initial begin
    int         phase;
    int         phase_words;
    int         pulse_idx;
    int         width;
    int         tick_pct;
    int         target;
    int         random_words;
    idle_mode_e mode;

    random_words = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: edges under the reset lockout are ignored
    repeat (4) send_pulse(1, 50);

    // Directed: zero references, short wins over long, all bits zero -> finish
    load_regs('0, '0, '0, '0, 4'b0000, '0);
    repeat (8) send_pulse(1, 50);

    // Directed: short references out of reach, long class only -> sector three
    load_regs('1, '0, '1, '0, 4'b1111, '0);
    repeat (8) send_pulse(1, 50);

    // Random phases, cycling through the idle patterns
    for (phase = 0;
         phase < MAX_PHASES && (random_words < RANDOM_WORDS || beacons_seen < MIN_BEACONS);
         phase++) begin
      mode     = idle_mode_e'(phase % 4);
      tick_pct = $urandom_range(60, 5);
      target   = PHASE_WORDS;
      if (phase == 0) begin
        load_regs('1, '0, '1, '0, 4'b1111, '0);
      end else if (phase == 1) begin
        // maximum lockout: nothing gets through
        load_regs(pick_ref(), pick_ref(), pick_ref(), pick_ref(), pick_class(), '1);
        target = LOCK_WORDS;
      end else begin
        load_regs(pick_ref(), pick_ref(), pick_ref(), pick_ref(), pick_class(),
                  pick_lockout());
      end

      case (mode)
        IDLE_NONE: begin idle_pct = 0;  stall_pct = 0;  end
        IDLE_SEND: begin idle_pct = 68; stall_pct = 0;  end
        IDLE_RECV: begin idle_pct = 0;  stall_pct = 68; end
        default:   begin idle_pct = 12; stall_pct = 12; end
      endcase

      phase_words = 0;
      pulse_idx   = 0;
      while (phase_words < target) begin
        width = pick_width();
        send_pulse(width, tick_pct);
        phase_words += width;
        pulse_idx++;
        if (pulse_idx == DRAIN_PULSE) drain_results();
      end
      random_words += phase_words;
    end

    // Let the last beacons out, then settle
    drain_results();
    repeat (8) @(posedge clk_i);

    if (mismatch_cnt == 0 && beacons_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
